FILE: src/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared widths and types for the vector normalization pipeline.
// ----------------------------------------------------------------------------
package vn_pkg;
    localparam int CW      = 32;
    localparam int UF      = 30;
    localparam int UW      = UF + 2;
    localparam int SW      = 2 * CW + 2;
    localparam int NW      = CW + UF;
    localparam int SQ_ST   = CW;
    localparam int DV_ST   = NW;
    localparam int LAT     = 2 + SQ_ST + 1 + DV_ST + 1;

    typedef logic [CW-1:0] t_comp;
    typedef logic [UW-1:0] t_unit;
    typedef logic [SW-1:0] t_sum;
endpackage

FILE: src/vn_sqrt.sv
// ----------------------------------------------------------------------------
// vn_sqrt
// Pipelined restoring square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vn_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  vn_pkg::t_sum         i_sum,
    input  vn_pkg::t_comp        i_mag [3],
    input  logic [2:0]           i_neg,
    output logic                 o_vld,
    output vn_pkg::t_comp        o_root,
    output vn_pkg::t_comp        o_mag [3],
    output logic [2:0]           o_neg
);
    import vn_pkg::*;

    logic         r_vld [SQ_ST+1];
    t_sum         r_rem [SQ_ST+1];
    t_comp        r_root [SQ_ST+1];
    t_comp        r_mag [SQ_ST+1][3];
    logic [2:0]   r_neg [SQ_ST+1];

    always_comb begin
        r_vld[0]  = i_vld;
        r_rem[0]  = i_sum;
        r_root[0] = '0;
        r_mag[0]  = i_mag;
        r_neg[0]  = i_neg;
    end

    for (genvar s = 0; s < SQ_ST; s++) begin : g_st
        localparam int B = CW - 1 - s;
        logic [SW:0] n_trial;
        logic        n_ok;
        always_comb begin
            // (2r + 2^b) * 2^b
            n_trial = ({{(SW+1-CW){1'b0}}, r_root[s]} << (B + 1))
                    + ({{SW{1'b0}}, 1'b1} << (2 * B));
            n_ok    = n_trial <= {1'b0, r_rem[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_rem[s+1]  <= n_ok ? SW'({1'b0, r_rem[s]} - n_trial) : r_rem[s];
            r_root[s+1] <= n_ok ? (r_root[s] | (CW'(1) << B)) : r_root[s];
            r_mag[s+1]  <= r_mag[s];
            r_neg[s+1]  <= r_neg[s];
        end
    end

    assign o_vld  = r_vld[SQ_ST];
    assign o_root = r_root[SQ_ST];
    assign o_mag  = r_mag[SQ_ST];
    assign o_neg  = r_neg[SQ_ST];
endmodule

FILE: src/vn_div.sv
// ----------------------------------------------------------------------------
// vn_div
// One division lane: pipelined restoring divider of a scaled magnitude.
// ----------------------------------------------------------------------------
module vn_div (
    input  logic            i_clk,
    input  vn_pkg::t_comp   i_mag,
    input  vn_pkg::t_comp   i_den,
    output vn_pkg::t_unit   o_quo
);
    import vn_pkg::*;

    logic [NW-1:0] r_num [DV_ST+1];
    logic [CW:0]   r_rem [DV_ST+1];
    t_comp         r_den [DV_ST+1];
    logic [NW-1:0] r_quo [DV_ST+1];

    always_comb begin
        r_num[0] = {i_mag, {UF{1'b0}}};
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_quo[0] = '0;
    end

    for (genvar s = 0; s < DV_ST; s++) begin : g_st
        logic [CW+1:0] n_sh;
        logic          n_ge;
        always_comb begin
            n_sh = {r_rem[s], r_num[s][NW-1]};
            n_ge = n_sh >= {2'b00, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            r_num[s+1] <= r_num[s] << 1;
            r_rem[s+1] <= n_ge ? (CW+1)'(n_sh - {2'b00, r_den[s]}) : n_sh[CW:0];
            r_den[s+1] <= r_den[s];
            r_quo[s+1] <= {r_quo[s][NW-2:0], n_ge};
        end
    end

    assign o_quo = r_quo[DV_ST][UW-1:0];
endmodule

FILE: src/vector3_normalize.sv
// ----------------------------------------------------------------------------
// vector3_normalize
// Throughput: one transaction per cycle; the square root and the three
// divider lanes are fully pipelined, one bit per stage. busy is never high.
// Reset: synchronous, active low; clears valids, min_length returns to 1.
// ----------------------------------------------------------------------------
module vector3_normalize (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  vn_pkg::t_comp         i_cfg_data,
    input  vn_pkg::t_comp         i_comp_x,
    input  vn_pkg::t_comp         i_comp_y,
    input  vn_pkg::t_comp         i_comp_z,
    output logic                  o_strobe,
    output vn_pkg::t_unit         o_unit_x,
    output vn_pkg::t_unit         o_unit_y,
    output vn_pkg::t_unit         o_unit_z,
    output vn_pkg::t_comp         o_vec_length,
    output logic                  o_was_zero
);
    import vn_pkg::*;

    t_comp       r_min;
    logic        r_v1, r_v2;
    t_comp       r_mag1 [3];
    logic [2:0]  r_neg1, r_neg2;
    logic [2*CW-1:0] r_sq [3];
    t_comp       r_mag2 [3];
    t_sum        r_sum;
    logic        w_sv;
    t_comp       w_root;
    t_comp       w_smag [3];
    logic [2:0]  w_sneg;
    logic        r_v3;
    t_comp       r_len3;
    logic        r_z3;
    logic        r_dv [DV_ST+1];
    t_comp       r_dlen [DV_ST+1];
    logic        r_dz [DV_ST+1];
    logic [2:0]  r_dneg [DV_ST+1];
    t_unit       w_q [3];
    t_comp       w_in [3];
    logic        r_stb;
    t_unit       r_u [3];
    t_comp       r_len;
    logic        r_wz;

    assign busy = 1'b0;
    assign w_in[0] = i_comp_x;
    assign w_in[1] = i_comp_y;
    assign w_in[2] = i_comp_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= CW'(1);
        end else if (i_cfg_we) begin
            r_min <= i_cfg_data;
        end
    end

    // magnitudes, then squares, then sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
        end
        for (int i = 0; i < 3; i++) begin
            r_neg1[i] <= w_in[i][CW-1];
            r_mag1[i] <= w_in[i][CW-1] ? CW'(-w_in[i]) : w_in[i];
            r_sq[i]   <= {{CW{1'b0}}, r_mag1[i]} * {{CW{1'b0}}, r_mag1[i]};
        end
        r_mag2 <= r_mag1;
        r_neg2 <= r_neg1;
    end

    always_comb begin
        r_sum = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    end

    vn_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_v2),
        .i_sum  (r_sum),
        .i_mag  (r_mag2),
        .i_neg  (r_neg2),
        .o_vld  (w_sv),
        .o_root (w_root),
        .o_mag  (w_smag),
        .o_neg  (w_sneg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= w_sv;
        end
        r_len3 <= w_root;
        r_z3   <= (w_root == '0) || (w_root < r_min);
    end

    logic [2:0] r_neg3;
    t_comp      r_mag3 [3];
    always_ff @(posedge i_clk) begin
        r_neg3 <= w_sneg;
        r_mag3 <= w_smag;
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        vn_div u_div (
            .i_clk(i_clk),
            .i_mag(r_mag3[l]),
            .i_den(r_len3 == '0 ? CW'(1) : r_len3),
            .o_quo(w_q[l])
        );
    end

    always_comb begin
        r_dv[0]   = r_v3;
        r_dlen[0] = r_len3;
        r_dz[0]   = r_z3;
        r_dneg[0] = r_neg3;
    end

    for (genvar s = 0; s < DV_ST; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else begin
                r_dv[s+1] <= r_dv[s];
            end
            r_dlen[s+1] <= r_dlen[s];
            r_dz[s+1]   <= r_dz[s];
            r_dneg[s+1] <= r_dneg[s];
        end
    end

    // merge: sign, zero flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stb <= 1'b0;
        end else begin
            r_stb <= r_dv[DV_ST];
        end
        for (int i = 0; i < 3; i++) begin
            r_u[i] <= r_dz[DV_ST] ? '0 : (r_dneg[DV_ST][i] ? UW'(-w_q[i]) : w_q[i]);
        end
        r_len <= r_dlen[DV_ST];
        r_wz  <= r_dz[DV_ST];
    end

    assign o_strobe     = r_stb;
    assign o_unit_x     = r_u[0];
    assign o_unit_y     = r_u[1];
    assign o_unit_z     = r_u[2];
    assign o_vec_length = r_len;
    assign o_was_zero   = r_wz;
endmodule
